// ===== sv/stereo_linear_resampler_core_assert.svh =====
// Assertion shorthands, clocked on clock and disabled during reset.
`ifndef STEREO_LINEAR_RESAMPLER_CORE_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_CORE_ASSERT_SVH

`define SLR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("resampler assertion failed");

`define SLR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("resampler assertion failed");

`endif

// ===== sv/slr_pkg.sv =====
package slr_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(2 * RING_DEPTH);
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = PTR_W + 1;

   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 16;
   localparam int STEP_W   = 18;
   localparam int TOTAL_W  = STEP_W + 1;

   localparam logic [PTR_W-1:0]   PTR_DEPTH   = PTR_W'(RING_DEPTH);
   localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(2 * RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]   CNT_SPAN    = CNT_W'(2 * RING_DEPTH);
   localparam logic [CNT_W-1:0]   CNT_DEPTH   = CNT_W'(RING_DEPTH);
   localparam logic [TOTAL_W-1:0] ONE_PERIOD  = TOTAL_W'(65536);
   localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_PHASE_STEP = 1'b0;

   // func codes
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left;
   } sample_pair_type;

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       starved;
   } rsp_item_type;

   typedef struct packed {
      logic            done;
      sample_pair_type pair;
   } interp_res_type;

   function automatic logic [IDX_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] q;
      q = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
      return q[IDX_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

// ===== sv/stereo_linear_resampler_core.sv =====
// Stereo linear-interpolating rate converter. A push item (func 0) stores one
// left/right pair in a 1024-entry ring held in single-port-read synchronous RAM;
// a push into a full ring is dropped. A tick item (func 1) returns one
// interpolated frame and then advances the phase by phase_step, popping one pair
// per whole period crossed (0 to 4 pairs). A tick occupies the block, which
// stalls requests until it completes; each pop is a RAM read in ST_POP_RD, then
// ST_POP_WR, where its registered data arrives. The frame is computed from the
// state as it stood when the tick was accepted, through a two-stage multiply,
// and waits in the output register if rsp_stall is high. With an empty ring a
// tick returns the frame with starved set and leaves the phase alone; if the
// ring runs dry mid-advance the remaining pops are skipped and only the
// fractional phase is kept. phase_step lies at byte address 0.
`include "stereo_linear_resampler_core_assert.svh"

module stereo_linear_resampler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  slr_pkg::req_item_type            req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output slr_pkg::rsp_item_type            rsp_item,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [slr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import slr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_WR,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [PTR_W-1:0]    rp_ff, wp_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic                starved_ff;
   sample_pair_type     prev_ff, next_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                res_rdy_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff;

   logic [CNT_W-1:0]    ring_count;
   logic                ring_empty, ring_full;
   logic                item_accept, tick_accept, push_wr;
   logic                rd_en, rsp_free, rsp_load, csr_wr;
   sample_pair_type     push_pair, rd_pair;
   interp_res_type      res;

   // ---- ring occupancy ----
   assign ring_count = (wp_ff >= rp_ff) ? CNT_W'(wp_ff - rp_ff)
                     : CNT_W'({1'b0, wp_ff} + CNT_SPAN - {1'b0, rp_ff});
   assign ring_empty = (wp_ff == rp_ff);
   assign ring_full  = (ring_count == CNT_DEPTH);

   assign req_stall   = (state_ff != ST_IDLE);
   assign item_accept = req_valid && (state_ff == ST_IDLE);
   assign tick_accept = item_accept && (req_item.func == FUNC_TICK);
   assign push_wr     = item_accept && (req_item.func == FUNC_PUSH) && !ring_full;

   assign push_pair.left  = req_item.left_in;
   assign push_pair.right = req_item.right_in;

   assign rd_en = (state_ff == ST_POP_RD) && (total_ff[TOTAL_W-1:PHASE_W] != '0)
                  && !ring_empty;

   assign total_in = ring_empty ? TOTAL_W'(phase_ff)
                   : TOTAL_W'(phase_ff) + TOTAL_W'(step_ff);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_FINISH) && rsp_free && (res_rdy_ff || res.done);

   slr_ring u_ring (
      .clock   (clock),
      .wr_en   (push_wr),
      .wr_idx  (ptr_index(wp_ff)),
      .wr_data (push_pair),
      .rd_en   (rd_en),
      .rd_idx  (ptr_index(rp_ff)),
      .rd_data (rd_pair)
   );

   slr_interp u_interp (
      .clock (clock),
      .reset (reset),
      .start (tick_accept),
      .prev  (prev_ff),
      .next  (next_ff),
      .phase (phase_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         phase_ff     <= '0;
         prev_ff      <= '0;
         next_ff      <= '0;
         res_rdy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // interpolator output holds until the next tick starts
         if (rsp_load) begin
            rsp_valid_ff          <= 1'b1;
            rsp_item_ff.left_out  <= res.pair.left;
            rsp_item_ff.right_out <= res.pair.right;
            rsp_item_ff.starved   <= starved_ff;
            res_rdy_ff            <= 1'b0;
         end else begin
            if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_ff <= 1'b0;
            end
            if (res.done) begin
               res_rdy_ff <= 1'b1;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (push_wr) begin
                  wp_ff <= ptr_inc(wp_ff);
               end
               if (tick_accept) begin
                  starved_ff <= ring_empty;
                  total_ff   <= total_in;
                  state_ff   <= ST_POP_RD;
               end
            end
            ST_POP_RD: begin
               if (rd_en) begin
                  rp_ff    <= ptr_inc(rp_ff);
                  total_ff <= total_ff - ONE_PERIOD;
                  state_ff <= ST_POP_WR;
               end else begin
                  phase_ff <= total_ff[PHASE_W-1:0];
                  state_ff <= ST_FINISH;
               end
            end
            ST_POP_WR: begin
               prev_ff  <= next_ff;
               next_ff  <= rd_pair;
               state_ff <= ST_POP_RD;
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wr && (csr_paddr[CSR_ADDR_W-1] == REG_PHASE_STEP)) begin
         step_ff <= csr_pwdata[STEP_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_PHASE_STEP: csr_prdata = 32'(step_ff);
         default:        csr_prdata = '0;
      endcase
   end

   `SLR_ASSERT_NOW(a_ring_bound, 1'b1, ring_count <= CNT_DEPTH)
   `SLR_ASSERT_NOW(a_pop_nonempty, rd_en, !ring_empty && (state_ff == ST_POP_RD))
   `SLR_ASSERT_NEXT(a_starve_keeps_phase, tick_accept && ring_empty, total_ff == TOTAL_W'(phase_ff))

endmodule

// ===== sv/slr_ring.sv =====
module slr_ring (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [slr_pkg::IDX_W-1:0]     wr_idx,
   input  slr_pkg::sample_pair_type      wr_data,
   input  logic                          rd_en,
   input  logic [slr_pkg::IDX_W-1:0]     rd_idx,
   output slr_pkg::sample_pair_type      rd_data
);
   import slr_pkg::*;

   sample_pair_type mem [RING_DEPTH];
   sample_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slr_interp.sv =====
module slr_interp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  slr_pkg::sample_pair_type      prev,
   input  slr_pkg::sample_pair_type      next,
   input  logic [slr_pkg::PHASE_W-1:0]   phase,
   output slr_pkg::interp_res_type       res
);
   import slr_pkg::*;

   // prev*(1-ph) + next*ph == prev + (next-prev)*ph; floor shift keeps low bits
   logic signed [SAMPLE_W:0]     diff_l, diff_r;
   logic signed [PHASE_W:0]      ph_s;
   logic signed [2*SAMPLE_W+1:0] prod_l_ff, prod_r_ff;
   sample_pair_type              prev_ff;
   sample_pair_type              out_ff;
   logic                         stage_ff;
   logic                         done_ff;

   assign diff_l = $signed({next.left[SAMPLE_W-1], next.left})
                 - $signed({prev.left[SAMPLE_W-1], prev.left});
   assign diff_r = $signed({next.right[SAMPLE_W-1], next.right})
                 - $signed({prev.right[SAMPLE_W-1], prev.right});
   assign ph_s   = $signed({1'b0, phase});

   always_ff @(posedge clock) begin
      if (start) begin
         prod_l_ff <= diff_l * ph_s;
         prod_r_ff <= diff_r * ph_s;
         prev_ff   <= prev;
      end
      if (stage_ff) begin
         out_ff.left  <= prev_ff.left  + prod_l_ff[PHASE_W +: SAMPLE_W];
         out_ff.right <= prev_ff.right + prod_r_ff[PHASE_W +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
   end

   assign res.done = done_ff;
   assign res.pair = out_ff;

endmodule
